### rtl/core/ps2md_pkg.sv
`default_nettype none

package ps2md_pkg;

   // Default coordinate width of the stored pointer position.
   localparam int COORD_BITS_DEFAULT = 12;

   // Depth of the packet queue between the byte collector and the executor.
   localparam int QUEUE_DEPTH = 2;

   // Field widths of the ports.
   localparam int SIZE_W  = 13;
   localparam int POINT_W = 12;
   localparam int MOVED_W = 13;

   // Register indexes of the configuration port.
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   // Reset values of the screen size registers.
   localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;

   // Result kinds.
   localparam logic [1:0] EVT_MOVE    = 2'd0;
   localparam logic [1:0] EVT_PRESS   = 2'd1;
   localparam logic [1:0] EVT_RELEASE = 2'd2;

   // One decoded packet: buttons as bit 0 left, bit 1 middle, bit 2 right,
   // and the two 9-bit two's complement deltas.
   typedef struct packed {
      logic [2:0]        buttons;
      logic signed [8:0] dx;
      logic signed [8:0] dy;
   } packet_type;

   // Fill status of the packet queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

### rtl/core/ps2md_core_top.sv
`default_nettype none

// PS/2 mouse packet decoder. Bytes from the mouse enter on the req_ channel
// and are grouped into header, X and Y bytes by a phase counter; the sync bit
// is not checked, and packets with an overflow bit are dropped. Each good
// packet moves the pointer, clamped to the screen size set through the csr_
// port (register 0 width, register 1 height, both to be written by the user
// only while idle, which the block itself does not enforce), and yields up to
// four results on the rsp_ channel: a move result when the position changed,
// then press or release results in the order left, middle, right, with
// last_of_packet set on the final one. Header and X bytes are always
// accepted, and a closing Y byte while the two-entry packet queue has room;
// the executor drains one result per cycle from its output register while
// rsp_stall does not hold it, and takes the next packet in the cycle its
// last result leaves.
module ps2_mouse_packet_decoder_core
   import ps2md_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_data_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_event_kind,
   output logic [POINT_W-1:0]        rsp_pointer_x,
   output logic [POINT_W-1:0]        rsp_pointer_y,
   output logic signed [MOVED_W-1:0] rsp_moved_x,
   output logic signed [MOVED_W-1:0] rsp_moved_y,
   output logic [1:0]                rsp_button_number,
   output logic                      rsp_last_of_packet,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_index,
   input  wire logic [SIZE_W-1:0]    csr_data
);

   logic [SIZE_W-1:0] screen_width_ff, screen_width_in;
   logic [SIZE_W-1:0] screen_height_ff, screen_height_in;
   queue_status_type  queue_status;
   logic              push;
   logic              pop;
   packet_type        push_packet;
   packet_type        head_packet;

   // The register file takes a transfer in every cycle.
   assign csr_ready = 1'b1;

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_data;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_data;
            default:           screen_width_in  = screen_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   ps2md_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .queue_status  (queue_status),
      .push          (push),
      .push_packet   (push_packet)
   );

   ps2md_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_packet (push_packet),
      .pop         (pop),
      .head_packet (head_packet),
      .status      (queue_status)
   );

   ps2md_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .screen_width       (screen_width_ff),
      .screen_height      (screen_height_ff),
      .queue_status       (queue_status),
      .head_packet        (head_packet),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_pointer_x      (rsp_pointer_x),
      .rsp_pointer_y      (rsp_pointer_y),
      .rsp_moved_x        (rsp_moved_x),
      .rsp_moved_y        (rsp_moved_y),
      .rsp_button_number  (rsp_button_number),
      .rsp_last_of_packet (rsp_last_of_packet)
   );

endmodule

`default_nettype wire

### rtl/core/ps2md_front.sv
`default_nettype none

module ps2md_front
   import ps2md_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_data_byte,
   input  wire queue_status_type queue_status,
   output logic                  push,
   output packet_type            push_packet
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_XBYTE  = 2'd1,
      PH_YBYTE  = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] xbyte_ff, xbyte_in;
   logic       accept;

   // Only the closing byte of a packet needs room in the queue.
   assign req_stall = (phase_ff == PH_YBYTE) && queue_status.full;
   assign accept    = req_valid && !req_stall;

   // A closing byte with neither overflow bit set forwards the packet.
   assign push = accept && (phase_ff == PH_YBYTE) && (header_ff[7:6] == 2'b00);

   // Header bit 0 is left, bit 1 right, bit 2 middle; bits 4 and 5 are signs.
   assign push_packet.buttons = {header_ff[1], header_ff[2], header_ff[0]};
   assign push_packet.dx      = $signed({header_ff[4], xbyte_ff});
   assign push_packet.dy      = $signed({header_ff[5], req_data_byte});

   // Phase sequencing of the byte stream.
   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      xbyte_in  = xbyte_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_XBYTE: begin
               xbyte_in = req_data_byte;
               phase_in = PH_YBYTE;
            end
            PH_YBYTE: begin
               phase_in = PH_HEADER;
            end
            default: begin
               header_in = req_data_byte;
               phase_in  = PH_XBYTE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
      header_ff <= header_in;
      xbyte_ff  <= xbyte_in;
   end

endmodule

`default_nettype wire

### rtl/core/ps2md_queue.sv
`default_nettype none

module ps2md_queue
   import ps2md_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire packet_type push_packet,
   input  wire logic       pop,
   output packet_type      head_packet,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   packet_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_packet  = entry_ff[rd_ptr_ff];

   // Pointer wrap and occupancy tracking.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_packet;
      end
   end

   // The collector never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("packet queue overrun");

   // The executor never takes from an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("packet queue underrun");

endmodule

`default_nettype wire

### rtl/core/ps2md_back.sv
`default_nettype none

module ps2md_back
   import ps2md_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [SIZE_W-1:0]        screen_width,
   input  wire logic [SIZE_W-1:0]        screen_height,
   input  wire queue_status_type         queue_status,
   input  wire packet_type               head_packet,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_event_kind,
   output logic [POINT_W-1:0]            rsp_pointer_x,
   output logic [POINT_W-1:0]            rsp_pointer_y,
   output logic signed [MOVED_W-1:0]     rsp_moved_x,
   output logic signed [MOVED_W-1:0]     rsp_moved_y,
   output logic [1:0]                    rsp_button_number,
   output logic                          rsp_last_of_packet
);

   localparam int SW = COORD_BITS + 2;
   localparam int LW = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;

   // Pending results: bit 0 move, bits 1 to 3 left, middle and right.
   logic [3:0]                  pending_ff, pending_in;
   logic [COORD_BITS-1:0]       pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]       pos_y_ff, pos_y_in;
   logic [2:0]                  held_ff, held_in;
   logic signed [MOVED_W-1:0]   moved_x_ff, moved_x_in;
   logic signed [MOVED_W-1:0]   moved_y_ff, moved_y_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  kind_ff, kind_in;
   logic [POINT_W-1:0]          point_x_ff, point_x_in;
   logic [POINT_W-1:0]          point_y_ff, point_y_in;
   logic signed [MOVED_W-1:0]   out_mx_ff, out_mx_in;
   logic signed [MOVED_W-1:0]   out_my_ff, out_my_in;
   logic [1:0]                  button_ff, button_in;
   logic                        last_ff, last_in;

   logic                        load_en;
   logic                        emit;
   logic [3:0]                  lowest;
   logic [3:0]                  after_emit;
   logic [COORD_BITS-1:0]       max_x, max_y;
   logic [COORD_BITS-1:0]       new_x, new_y;
   logic signed [COORD_BITS:0]  diff_x, diff_y;
   logic                        moved;
   logic [2:0]                  changed;

   // Largest coordinate for a screen size: size zero counts as one, and the
   // limit never passes the coordinate range.
   function automatic logic [COORD_BITS-1:0] max_coord(input logic [SIZE_W-1:0] size);
      logic [LW-1:0] eff;
      logic [LW-1:0] cap;
      eff = (size == '0) ? LW'(1) : LW'(size);
      cap = LW'(1) << COORD_BITS;
      if (eff > cap) begin
         eff = cap;
      end
      return COORD_BITS'(eff - LW'(1));
   endfunction

   // Adds a delta to a coordinate and clamps the sum to 0..limit.
   function automatic logic [COORD_BITS-1:0] step_axis(
      input logic [COORD_BITS-1:0] pos,
      input logic signed [8:0]     delta,
      input logic [COORD_BITS-1:0] limit
   );
      logic signed [SW-1:0] sum;
      sum = $signed({2'b00, pos}) + SW'(delta);
      if (sum[SW-1]) begin
         return '0;
      end else if (sum[COORD_BITS:0] > {1'b0, limit}) begin
         return limit;
      end else begin
         return sum[COORD_BITS-1:0];
      end
   endfunction

   assign max_x = max_coord(screen_width);
   assign max_y = max_coord(screen_height);

   // Position update for the packet at the head of the queue.
   assign new_x   = step_axis(pos_x_ff, head_packet.dx, max_x);
   assign new_y   = step_axis(pos_y_ff, head_packet.dy, max_y);
   assign diff_x  = $signed({1'b0, new_x}) - $signed({1'b0, pos_x_ff});
   assign diff_y  = $signed({1'b0, new_y}) - $signed({1'b0, pos_y_ff});
   assign moved   = (new_x != pos_x_ff) || (new_y != pos_y_ff);
   assign changed = head_packet.buttons ^ held_ff;

   // One pending result leaves per cycle when the output register is free.
   assign load_en    = !rsp_valid_ff || !rsp_stall;
   assign emit       = load_en && (pending_ff != '0);
   assign lowest     = pending_ff & (~pending_ff + 4'd1);
   assign after_emit = emit ? (pending_ff & ~lowest) : pending_ff;
   assign pop        = !queue_status.empty && (after_emit == '0);

   // Executor state: the next packet is taken as the last result leaves.
   always_comb begin
      pending_in = after_emit;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      held_in    = held_ff;
      moved_x_in = moved_x_ff;
      moved_y_in = moved_y_ff;
      if (pop) begin
         pending_in = {changed, moved};
         pos_x_in   = new_x;
         pos_y_in   = new_y;
         held_in    = head_packet.buttons;
         moved_x_in = MOVED_W'(diff_x);
         moved_y_in = MOVED_W'(diff_y);
      end
   end

   // Output register contents for the lowest pending result.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      point_x_in   = point_x_ff;
      point_y_in   = point_y_ff;
      out_mx_in    = out_mx_ff;
      out_my_in    = out_my_ff;
      button_in    = button_ff;
      last_in      = last_ff;
      if (load_en) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         point_x_in = POINT_W'(pos_x_ff);
         point_y_in = POINT_W'(pos_y_ff);
         last_in    = (after_emit == '0);
         out_mx_in  = '0;
         out_my_in  = '0;
         button_in  = 2'd0;
         kind_in    = EVT_MOVE;
         priority case (1'b1)
            lowest[0]: begin
               out_mx_in = moved_x_ff;
               out_my_in = moved_y_ff;
            end
            lowest[1]: begin
               button_in = 2'd0;
               kind_in   = held_ff[0] ? EVT_PRESS : EVT_RELEASE;
            end
            lowest[2]: begin
               button_in = 2'd1;
               kind_in   = held_ff[1] ? EVT_PRESS : EVT_RELEASE;
            end
            default: begin
               button_in = 2'd2;
               kind_in   = held_ff[2] ? EVT_PRESS : EVT_RELEASE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      moved_x_ff <= moved_x_in;
      moved_y_ff <= moved_y_in;
      kind_ff    <= kind_in;
      point_x_ff <= point_x_in;
      point_y_ff <= point_y_in;
      out_mx_ff  <= out_mx_in;
      out_my_ff  <= out_my_in;
      button_ff  <= button_in;
      last_ff    <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_pointer_x      = point_x_ff;
   assign rsp_pointer_y      = point_y_ff;
   assign rsp_moved_x        = out_mx_ff;
   assign rsp_moved_y        = out_my_ff;
   assign rsp_button_number  = button_ff;
   assign rsp_last_of_packet = last_ff;

   // A pending move always carries a nonzero change.
   assert property (@(posedge clock) disable iff (reset)
      pending_ff[0] |-> (moved_x_ff != '0 || moved_y_ff != '0))
      else $error("move pending without a position change");

   // Results of one packet leave without gaps until the last one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_packet) |=> rsp_valid)
      else $error("gap inside the results of one packet");

   // A new packet is taken only once the previous one has no result left.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (after_emit == '0))
      else $error("packet taken while results are pending");

endmodule

`default_nettype wire
